@@ hw/rtl/deq_pkg.sv @@
package deq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int COUNT_OUT_W  = 5;

    typedef enum logic [1:0] {
        CMD_INS_HEAD = 2'd0,
        CMD_INS_TAIL = 2'd1,
        CMD_REM_HEAD = 2'd2,
        CMD_REVERSE  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [VALUE_W-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic                      success;
        logic signed [VALUE_W-1:0] removed_value;
        logic [COUNT_OUT_W-1:0]    element_count;
    } t_out_item;

endpackage

@@ hw/rtl/double_ended_queue_with_reverse_unit.sv @@
// Channel   Handshake         Payload
// command   start / busy      i_item   (command, item_value)
// result    o_valid strobe    o_result (success, removed_value, element_count)
//
// Each command is accepted while start is high and its result strobes on the next cycle.
// Busy stays low, so a new command may be accepted in every cycle.
// The ring storage has one write port and one registered read port, and a remove
// reads its entry in the accept cycle so the data is ready with the strobe.
// Reset clears the pointers, the count and the reverse flag; the storage is not cleared.
// The receiver cannot stall, so each result is valid for exactly one cycle.
module double_ended_queue_with_reverse_unit #(
    parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  deq_pkg::t_in_item  i_item,
    output logic               o_valid,
    output deq_pkg::t_out_item o_result
);
    import deq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic               accept;
    logic               we, re;
    logic [AW-1:0]      waddr, raddr;
    logic [VALUE_W-1:0] wdata, rdata;
    logic               success, was_remove;
    logic [COUNT_OUT_W-1:0] count;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    deq_ctrl #(
        .CAPACITY(CAPACITY),
        .AW      (AW),
        .CW      (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .o_valid     (o_valid),
        .o_success   (success),
        .o_was_remove(was_remove),
        .o_count     (count)
    );

    deq_ram #(
        .DEPTH(CAPACITY),
        .AW   (AW),
        .DW   (VALUE_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        o_result.success       = success;
        o_result.removed_value = was_remove ? rdata : '0;
        o_result.element_count = count;
    end

endmodule

@@ hw/rtl/deq_ram.sv @@
module deq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/deq_ctrl.sv @@
module deq_ctrl #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int CW       = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  deq_pkg::t_in_item         i_item,
    output logic                      o_we,
    output logic [AW-1:0]             o_waddr,
    output logic [deq_pkg::VALUE_W-1:0] o_wdata,
    output logic                      o_re,
    output logic [AW-1:0]             o_raddr,
    output logic                      o_valid,
    output logic                      o_success,
    output logic                      o_was_remove,
    output logic [deq_pkg::COUNT_OUT_W-1:0] o_count
);
    import deq_pkg::*;

    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    logic [AW-1:0] r_front, n_front;
    logic [AW-1:0] r_back, n_back;
    logic [CW-1:0] r_count, n_count;
    logic          r_rev, n_rev;
    logic          r_valid, r_success, r_was_remove;
    logic [COUNT_OUT_W-1:0] r_count_out;

    logic [AW-1:0] front_prev, back_prev, back_next, front_next;
    logic          ok, ins_at_back;
    t_cmd          cmd;

    assign cmd         = t_cmd'(i_item.command);
    assign front_prev  = (r_front == '0) ? LAST_IDX : r_front - AW'(1);
    assign front_next  = (r_front == LAST_IDX) ? '0 : r_front + AW'(1);
    assign back_prev   = (r_back == '0) ? LAST_IDX : r_back - AW'(1);
    assign back_next   = (r_back == LAST_IDX) ? '0 : r_back + AW'(1);
    assign ins_at_back = (cmd == CMD_INS_HEAD) ? r_rev : ~r_rev;

    always_comb begin
        n_front = r_front;
        n_back  = r_back;
        n_count = r_count;
        n_rev   = r_rev;
        ok      = 1'b0;
        o_we    = 1'b0;
        o_waddr = r_back;
        o_wdata = i_item.item_value;
        o_re    = 1'b0;
        o_raddr = r_front;
        if (i_accept) begin
            case (cmd)
                CMD_INS_HEAD, CMD_INS_TAIL: begin
                    if (r_count != FULL_CNT) begin
                        ok      = 1'b1;
                        o_we    = 1'b1;
                        n_count = r_count + CW'(1);
                        if (ins_at_back) begin
                            o_waddr = r_back;
                            n_back  = back_next;
                        end else begin
                            o_waddr = front_prev;
                            n_front = front_prev;
                        end
                    end
                end
                CMD_REM_HEAD: begin
                    if (r_count != '0) begin
                        ok      = 1'b1;
                        o_re    = 1'b1;
                        n_count = r_count - CW'(1);
                        if (r_rev) begin
                            o_raddr = back_prev;
                            n_back  = back_prev;
                        end else begin
                            o_raddr = r_front;
                            n_front = front_next;
                        end
                    end
                end
                default: begin
                    ok    = 1'b1;
                    n_rev = ~r_rev;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
            r_rev   <= n_rev;
            r_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_success    <= ok;
            r_was_remove <= ok && (cmd == CMD_REM_HEAD);
            r_count_out  <= COUNT_OUT_W'(n_count);
        end
    end

    assign o_valid      = r_valid;
    assign o_success    = r_success;
    assign o_was_remove = r_was_remove;
    assign o_count      = r_count_out;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import deq_pkg::*;

    class deque_tracker;
        localparam int DEPTH = CAPACITY_DEF;

        logic [VALUE_W-1:0] ring [DEPTH];
        int                 front_slot;
        int                 back_slot;
        int                 held;
        bit                 flipped;
        t_out_item          awaited [$];
        int                 errors;

        function void note_command(t_in_item it);
            t_out_item exp;
            bit        to_back;
            exp = '0;
            case (t_cmd'(it.command))
                CMD_INS_HEAD, CMD_INS_TAIL: begin
                    if (held < DEPTH) begin
                        to_back = (it.command == CMD_INS_HEAD) ? flipped : !flipped;
                        if (to_back) begin
                            ring[back_slot] = it.item_value;
                            back_slot = (back_slot + 1) % DEPTH;
                        end else begin
                            front_slot = (front_slot + DEPTH - 1) % DEPTH;
                            ring[front_slot] = it.item_value;
                        end
                        held++;
                        exp.success = 1'b1;
                    end
                end
                CMD_REM_HEAD: begin
                    if (held > 0) begin
                        if (!flipped) begin
                            exp.removed_value = ring[front_slot];
                            front_slot = (front_slot + 1) % DEPTH;
                        end else begin
                            back_slot = (back_slot + DEPTH - 1) % DEPTH;
                            exp.removed_value = ring[back_slot];
                        end
                        held--;
                        exp.success = 1'b1;
                    end
                end
                default: begin
                    flipped = !flipped;
                    exp.success = 1'b1;
                end
            endcase
            exp.element_count = held[COUNT_OUT_W-1:0];
            awaited.push_back(exp);
        endfunction

        function void compare_field(string name, logic [VALUE_W-1:0] exp_v,
                                    logic [VALUE_W-1:0] got_v);
            if (exp_v !== got_v) begin
                errors++;
                $display("%0t %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t result with no command pending: expected none, actual %p",
                         $time, got);
            end else begin
                exp = awaited.pop_front();
                compare_field("success", VALUE_W'(exp.success), VALUE_W'(got.success));
                compare_field("removed_value", exp.removed_value, got.removed_value);
                compare_field("element_count", VALUE_W'(exp.element_count),
                              VALUE_W'(got.element_count));
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    logic      o_valid;
    t_out_item o_result;

    deque_tracker tracker = new();

    double_ended_queue_with_reverse_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #200us;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1) tracker.check_result(o_result);
            if (start && busy === 1'b0) tracker.note_command(i_item);
        end
    end

    function automatic logic [VALUE_W-1:0] rand_value();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 32'h8000_0000;
        if (r == 1) return 32'h7FFF_FFFF;
        return $urandom;
    endfunction

    task automatic send_item(input t_cmd cmd, input logic [VALUE_W-1:0] v, input int idle_pct);
        t_in_item it;
        it.command = cmd;
        it.item_value = v;
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        while ($urandom_range(99) < idle_pct) begin
            it.command = 2'($urandom_range(3));
            it.item_value = $urandom;
            start <= 1'b0;
            i_item <= it;
            @(posedge i_clk);
        end
    endtask

    task automatic run_directed(input int idle_pct);
        send_item(CMD_REM_HEAD, 32'h1234_5678, idle_pct);
        send_item(CMD_REVERSE, 32'hFFFF_FFFF, idle_pct);
        send_item(CMD_REVERSE, 32'h0, idle_pct);
        send_item(CMD_INS_HEAD, 32'h7FFF_FFFF, idle_pct);
        send_item(CMD_REVERSE, 32'h5555_5555, idle_pct);
        send_item(CMD_REM_HEAD, 32'hAAAA_AAAA, idle_pct);
        send_item(CMD_INS_TAIL, 32'h8000_0000, idle_pct);
        send_item(CMD_INS_HEAD, 32'h0, idle_pct);
        send_item(CMD_INS_TAIL, 32'hFFFF_FFFF, idle_pct);
        for (int k = 0; k < 13; k++)
            send_item((k % 2) ? CMD_INS_TAIL : CMD_INS_HEAD, rand_value(), idle_pct);
        send_item(CMD_INS_HEAD, 32'h7FFF_FFFF, idle_pct);
        send_item(CMD_INS_TAIL, 32'h8000_0000, idle_pct);
        send_item(CMD_REVERSE, 32'h0, idle_pct);
        send_item(CMD_REM_HEAD, 32'h0, idle_pct);
    endtask

    task automatic run_random(input int count, input int idle_pct);
        int   mode;
        int   r;
        t_cmd c;
        mode = 2;
        for (int k = 0; k < count; k++) begin
            if (k % 32 == 0) mode = $urandom_range(2);
            r = $urandom_range(99);
            case (mode)
                0: c = (r < 40) ? CMD_INS_HEAD : (r < 75) ? CMD_INS_TAIL :
                       (r < 92) ? CMD_REM_HEAD : CMD_REVERSE;
                1: c = (r < 15) ? CMD_INS_HEAD : (r < 30) ? CMD_INS_TAIL :
                       (r < 90) ? CMD_REM_HEAD : CMD_REVERSE;
                default: c = (r < 30) ? CMD_INS_HEAD : (r < 60) ? CMD_INS_TAIL :
                             (r < 90) ? CMD_REM_HEAD : CMD_REVERSE;
            endcase
            send_item(c, rand_value(), idle_pct);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed(31);
        run_random(225, 31);
        run_random(250, 54);
        run_random(250, 0);
        start <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/deq_pkg.sv
hw/rtl/deq_ram.sv
hw/rtl/deq_ctrl.sv
hw/rtl/double_ended_queue_with_reverse_unit.sv
tb/sv/tb.sv
